[design/tshb_pkg.sv]
package tshb_pkg;

    // Fixed header values
    localparam int unsigned HDR_LEN         = 20;
    localparam int unsigned MAX_PAYLOAD_DEF = 65515;
    localparam logic [15:0] WINDOW_SIZE     = 16'd5840;
    localparam logic [15:0] PROTO_TCP       = 16'd6;
    localparam logic [15:0] SEQ_HI_WORD     = 16'h0100;
    localparam logic [31:0] SEQ_WORD        = 32'h0100_0000;
    localparam logic [7:0]  DATA_OFFSET     = 8'h50;

    // Control bit positions on the input
    localparam int unsigned CTRL_SYN = 0;
    localparam int unsigned CTRL_ACK = 1;
    localparam int unsigned CTRL_RST = 2;

    // Register map
    localparam int unsigned APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] REG_OWN_ADDR = 2'd0;

    // Descriptor queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        last_byte;
        logic [31:0] dest_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [2:0]  ctrl_bits;
    } tshb_in_t;

    typedef struct packed {
        logic [63:0] header_front;
        logic [63:0] header_middle;
        logic [31:0] header_tail;
        logic [15:0] segment_length;
        logic        status;
    } tshb_out_t;

    // One finished segment, handed from front to back
    typedef struct packed {
        logic        oversize;
        logic [15:0] sum;
        logic        odd;
        logic [7:0]  held;
        logic [15:0] tcp_len;
        logic [31:0] dest_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [2:0]  ctrl;
    } tshb_desc_t;

    // One's-complement add of two 16-bit words with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Header word 12: data offset and flags
    function automatic logic [15:0] hdr_word12(input logic [2:0] ctrl);
        return {DATA_OFFSET, 3'b000, ctrl[CTRL_ACK], 1'b0, ctrl[CTRL_RST],
                ctrl[CTRL_SYN], 1'b0};
    endfunction

endpackage

[design/tshb_front.sv]
module tshb_front #(
    parameter int unsigned MAX_PAYLOAD = tshb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tshb_pkg::tshb_in_t   s_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output tshb_pkg::tshb_desc_t push_desc
);
    import tshb_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 2);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_PAYLOAD + 1);

    logic [15:0]      sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             odd_reg, odd_next;
    logic [7:0]       held_reg, held_next;
    logic             in_seg_reg, in_seg_next;
    logic [31:0]      dest_reg, dest_next;
    logic [15:0]      sport_reg, sport_next;
    logic [15:0]      dport_reg, dport_next;
    logic [2:0]       ctrl_reg, ctrl_next;
    logic             accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Fold one byte into the running sum; latch segment fields on the first transaction
    always_comb begin
        logic first;
        logic [15:0]      sum_b;
        logic [CNT_W-1:0] count_b;
        logic             odd_b;
        logic [7:0]       held_b;
        first   = !in_seg_reg;
        sum_b   = first ? 16'd0 : sum_reg;
        count_b = first ? '0 : count_reg;
        odd_b   = first ? 1'b0 : odd_reg;
        held_b  = first ? 8'd0 : held_reg;
        dest_next  = first ? s_data.dest_addr   : dest_reg;
        sport_next = first ? s_data.source_port : sport_reg;
        dport_next = first ? s_data.dest_port   : dport_reg;
        ctrl_next  = first ? s_data.ctrl_bits   : ctrl_reg;
        sum_next   = sum_b;
        count_next = count_b;
        odd_next   = odd_b;
        held_next  = held_b;
        if (s_data.has_byte) begin
            if (count_b < CNT_MAX) begin
                if (odd_b) begin
                    sum_next = oc_add(sum_b, {held_b, s_data.payload_byte});
                    odd_next = 1'b0;
                end else begin
                    held_next = s_data.payload_byte;
                    odd_next  = 1'b1;
                end
                count_next = count_b + 1'b1;
            end else begin
                count_next = CNT_OVER;
            end
        end
        in_seg_next = !s_data.last_byte;
    end

    // Hand a closed segment to the queue
    assign push_valid            = accept && s_data.last_byte;
    assign push_desc.oversize    = count_next > CNT_MAX;
    assign push_desc.sum         = sum_next;
    assign push_desc.odd         = odd_next;
    assign push_desc.held        = held_next;
    assign push_desc.tcp_len     = 16'(count_next) + 16'(HDR_LEN);
    assign push_desc.dest_addr   = dest_next;
    assign push_desc.source_port = sport_next;
    assign push_desc.dest_port   = dport_next;
    assign push_desc.ctrl        = ctrl_next;

    // Segment state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_seg_reg <= 1'b0;
            count_reg  <= '0;
            odd_reg    <= 1'b0;
            sum_reg    <= 16'd0;
        end else if (accept) begin
            in_seg_reg <= in_seg_next;
            count_reg  <= count_next;
            odd_reg    <= odd_next;
            sum_reg    <= sum_next;
        end
    end

    // Latched segment fields
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg  <= held_next;
            dest_reg  <= dest_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            ctrl_reg  <= ctrl_next;
        end
    end

endmodule

[design/tshb_queue.sv]
module tshb_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  tshb_pkg::tshb_desc_t push_desc,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output tshb_pkg::tshb_desc_t pop_desc
);
    import tshb_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    tshb_desc_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_desc   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the incoming descriptor
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[design/tshb_back.sv]
module tshb_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          own_addr,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  tshb_pkg::tshb_desc_t pop_desc,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tshb_pkg::tshb_out_t  m_data
);
    import tshb_pkg::*;

    localparam logic [15:0] CONST_WORDS = PROTO_TCP + SEQ_HI_WORD + WINDOW_SIZE;

    logic        advance;
    logic        s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [17:0] p0_reg, p1_reg, p2_reg;
    logic [19:0] total_reg;
    logic        s1_over_reg, s2_over_reg;
    logic [15:0] s1_len_reg, s2_len_reg;
    logic [15:0] s1_sport_reg, s2_sport_reg;
    logic [15:0] s1_dport_reg, s2_dport_reg;
    logic [15:0] s1_w12_reg, s2_w12_reg;
    logic [15:0] pad_word, w12;
    logic [16:0] fold1;
    logic [15:0] fold2;
    tshb_out_t   out_reg, out_next;

    // Whole pipe moves when the output register is free
    assign advance   = !out_valid_reg || m_ready;
    assign pop_ready = advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign pad_word = pop_desc.odd ? {pop_desc.held, 8'h00} : 16'd0;
    assign w12      = hdr_word12(pop_desc.ctrl);

    // Stage 1: three partial sums of the checksum words
    always_ff @(posedge aclk) begin
        if (advance) begin
            p0_reg <= {2'b00, pop_desc.sum} + {2'b00, pad_word}
                    + {2'b00, own_addr[31:16]} + {2'b00, own_addr[15:0]};
            p1_reg <= {2'b00, pop_desc.dest_addr[31:16]} + {2'b00, pop_desc.dest_addr[15:0]}
                    + {2'b00, pop_desc.source_port} + {2'b00, pop_desc.dest_port};
            p2_reg <= {2'b00, pop_desc.tcp_len} + {2'b00, w12} + {2'b00, CONST_WORDS};
            s1_over_reg  <= pop_desc.oversize;
            s1_len_reg   <= pop_desc.tcp_len;
            s1_sport_reg <= pop_desc.source_port;
            s1_dport_reg <= pop_desc.dest_port;
            s1_w12_reg   <= w12;
        end
    end

    // Stage 2: total of the partial sums
    always_ff @(posedge aclk) begin
        if (advance) begin
            total_reg    <= {2'b00, p0_reg} + {2'b00, p1_reg} + {2'b00, p2_reg};
            s2_over_reg  <= s1_over_reg;
            s2_len_reg   <= s1_len_reg;
            s2_sport_reg <= s1_sport_reg;
            s2_dport_reg <= s1_dport_reg;
            s2_w12_reg   <= s1_w12_reg;
        end
    end

    // Stage 3: end-around fold, complement and assemble the header
    assign fold1 = {1'b0, total_reg[15:0]} + {13'd0, total_reg[19:16]};
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

    always_comb begin
        out_next = '0;
        if (s2_over_reg) begin
            out_next.status = 1'b1;
        end else begin
            out_next.header_front   = {s2_sport_reg, s2_dport_reg, SEQ_WORD};
            out_next.header_middle  = {32'd0, s2_w12_reg, WINDOW_SIZE};
            out_next.header_tail    = {~fold2, 16'd0};
            out_next.segment_length = s2_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // Valid bits down the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

endmodule

[design/tcp_segment_header_builder_unit.sv]
// TCP segment header builder.
// Input channel (s_valid/s_ready/s_data) takes at most one payload byte per
// transaction; the first transaction of a segment supplies the ports,
// destination address and control bits, and the transaction with
// last_byte set closes the segment. The result channel
// (m_valid/m_ready/m_data) returns one header per segment: 20 header
// bytes with the pseudo-header checksum, the TCP length and a status bit.
// One input transaction is taken per cycle while s_ready is high; the
// running checksum costs one 16-bit end-around add per byte pair in the
// front part. The result of a closing transaction passes through the
// queue, two adder stages and the output register.
// A four-entry descriptor queue sits between front and back, so input
// keeps flowing while the receiver stalls until the queue holds four
// closed segments behind up to three in the back pipe; then s_ready drops.
// Synchronous reset empties the queue and the pipe and sets own_addr to
// zero. own_addr is written through the APB port at address 0; the user
// must write it only while the block is idle, which the block itself does not enforce.
module tcp_segment_header_builder_unit #(
    parameter int unsigned MAX_PAYLOAD = tshb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tshb_pkg::tshb_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tshb_pkg::tshb_out_t                 m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tshb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import tshb_pkg::*;

    logic        push_valid, push_ready, pop_valid, pop_ready;
    tshb_desc_t  push_desc, pop_desc;
    logic [31:0] own_addr_reg;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_OWN_ADDR) ? own_addr_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= 32'd0;
        end else if (psel && penable && pwrite && pready && paddr == REG_OWN_ADDR) begin
            own_addr_reg <= pwdata;
        end
    end

    tshb_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_desc (push_desc)
    );

    tshb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_desc (push_desc),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc)
    );

    tshb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .own_addr (own_addr_reg),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_desc (pop_desc),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // An oversize result carries no header
    a_oversize_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.header_front == 64'd0
            && m_data.header_middle == 64'd0 && m_data.header_tail == 32'd0
            && m_data.segment_length == 16'd0)
        else $error("oversize result carries header data");

    // A valid header always counts its own 20 bytes
    a_length_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.status |-> m_data.segment_length >= 16'(HDR_LEN))
        else $error("segment length below header size");

    // Fixed header words sit in place on every valid header
    a_fixed_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.status |-> m_data.header_front[31:0] == SEQ_WORD
            && m_data.header_middle[15:0] == WINDOW_SIZE
            && m_data.header_middle[31:24] == DATA_OFFSET
            && m_data.header_tail[15:0] == 16'd0)
        else $error("fixed header words corrupted");

    // Pushing into the queue only happens while input is taken
    a_push_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> s_valid && s_ready && s_data.last_byte)
        else $error("descriptor pushed without closing transaction");

endmodule
